[sv/bitmap_slot_allocator_assert.svh]
// ---------------------------------------------------------------------------
// bitmap slot allocator assertion macros
// Short forms for concurrent assertions clocked on the rising edge.
// ---------------------------------------------------------------------------
`ifndef BITMAP_SLOT_ALLOCATOR_ASSERT_SVH
`define BITMAP_SLOT_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define BSA_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
   else $error(msg);

// next-cycle implication
`define BSA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
   else $error(msg);

`endif

[sv/bsa_pkg.sv]
// ---------------------------------------------------------------------------
// bitmap slot allocator package
// Shared widths, defaults, operation and status codes, controller states.
// ---------------------------------------------------------------------------
package bsa_pkg;

   localparam int MAP_BYTES_DEF = 512;
   localparam int MAX_FIND_DEF  = 16;
   localparam int BYTE_BITS     = 8;

   localparam int OP_W     = 2;
   localparam int SLOT_W   = 12;
   localparam int COUNT_W  = 5;
   localparam int STATUS_W = 2;
   localparam int ACTIVE_W = 10;

   localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 10'd512;

   typedef enum logic [OP_W-1:0] {
      OP_FIND  = 2'd0,
      OP_SET   = 2'd1,
      OP_CLEAR = 2'd2,
      OP_TEST  = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_SHORT = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MODIFY,
      S_SINGLE,
      S_SCAN,
      S_EMIT_RD,
      S_EMIT_OUT
   } state_type;

endpackage

[sv/bsa_if.sv]
// ---------------------------------------------------------------------------
// bitmap slot allocator channels
// Request, response and register write channels with valid/ready.
// ---------------------------------------------------------------------------
interface bsa_req_if;
   logic                           valid;
   logic                           ready;
   logic [bsa_pkg::OP_W-1:0]       op;
   logic [bsa_pkg::SLOT_W-1:0]     slot_index;
   logic [bsa_pkg::COUNT_W-1:0]    count;

   modport source (output valid, op, slot_index, count, input ready);
   modport sink   (input valid, op, slot_index, count, output ready);
endinterface

interface bsa_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [bsa_pkg::SLOT_W-1:0]     found_index;
   logic                           bit_value;
   logic [bsa_pkg::STATUS_W-1:0]   status;
   logic                           last;

   modport source (output valid, found_index, bit_value, status, last, input ready);
   modport sink   (input valid, found_index, bit_value, status, last, output ready);
endinterface

interface bsa_csr_if;
   logic                           valid;
   logic                           ready;
   logic [bsa_pkg::ACTIVE_W-1:0]   active_bytes;

   modport source (output valid, active_bytes, input ready);
   modport sink   (input valid, active_bytes, output ready);
endinterface

[sv/bsa_map_ram.sv]
// ---------------------------------------------------------------------------
// bitmap store
// Byte-wide synchronous memory, one read and one write port, registered
// read data, with a zero fill sweep after reset.
// ---------------------------------------------------------------------------
module bsa_map_ram #(
   parameter int DEPTH  = bsa_pkg::MAP_BYTES_DEF,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           rd_en,
   input  logic [ADDR_W-1:0]              rd_addr,
   output logic [bsa_pkg::BYTE_BITS-1:0]  rd_data,
   input  logic                           wr_en,
   input  logic [ADDR_W-1:0]              wr_addr,
   input  logic [bsa_pkg::BYTE_BITS-1:0]  wr_data,
   output logic                           busy
);

   logic [bsa_pkg::BYTE_BITS-1:0] mem [DEPTH];
   logic [bsa_pkg::BYTE_BITS-1:0] rd_data_ff;
   logic                          clr_ff;
   logic [ADDR_W-1:0]             clr_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_ff) begin
         clr_addr_ff <= clr_addr_ff + ADDR_W'(1);
         if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
            clr_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (clr_ff) begin
         mem[clr_addr_ff] <= '0;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign busy    = clr_ff;

endmodule

[sv/bitmap_slot_allocator.sv]
// ---------------------------------------------------------------------------
// bitmap slot allocator: set/clear/test read the bitmap byte, set/clear write it back; out of range skips the access
// find: scans the bitmap byte by byte, listing free slots taken, then emits one response per listed slot
// the registered read of the bitmap memory and the output register set the pace
// reset: zero sweep of the bitmap, req_ready low meanwhile
// ---------------------------------------------------------------------------
module bitmap_slot_allocator #(
   parameter int MAP_BYTES = bsa_pkg::MAP_BYTES_DEF,
   parameter int MAX_FIND  = bsa_pkg::MAX_FIND_DEF
) (
   input  logic   clock,
   input  logic   reset,
   bsa_req_if.sink   req_bus,
   bsa_rsp_if.source rsp_bus,
   bsa_csr_if.sink   csr_bus
);

   localparam int ADDR_W = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
   localparam int NB_W   = $clog2(MAP_BYTES + 1);
   localparam int CW     = ((NB_W > bsa_pkg::ACTIVE_W) ? NB_W : bsa_pkg::ACTIVE_W) + 1;
   localparam int FW     = $clog2(MAX_FIND + 1);
   localparam int LW     = (MAX_FIND > 1) ? $clog2(MAX_FIND) : 1;
   localparam int WW     = ((FW > bsa_pkg::COUNT_W) ? FW : bsa_pkg::COUNT_W) + 1;
   localparam int SW     = bsa_pkg::SLOT_W;
   localparam int BB     = bsa_pkg::BYTE_BITS;

   bsa_pkg::state_type   state_ff, state_in;
   logic [bsa_pkg::OP_W-1:0] op_ff, op_in;
   logic [SW-1:0]        slot_ff, slot_in;
   logic [FW-1:0]        want_ff, want_in;
   logic [ADDR_W-1:0]    byte_ff, byte_in;
   logic [FW-1:0]        found_ff, found_in;
   logic [FW-1:0]        emit_ff, emit_in;
   logic [BB-1:0]        work_ff, work_in;
   logic                 fresh_ff, fresh_in;
   logic [SW-1:0]        res_index_ff, res_index_in;
   logic                 res_bit_ff, res_bit_in;
   bsa_pkg::status_type  res_status_ff, res_status_in;
   logic [bsa_pkg::ACTIVE_W-1:0] active_ff;

   logic                 rsp_valid_ff;
   logic [SW-1:0]        rsp_index_ff, rsp_index_in;
   logic                 rsp_bit_ff, rsp_bit_in;
   bsa_pkg::status_type  rsp_status_ff, rsp_status_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic                 rsp_load, rsp_free;

   logic                 map_rd_en, map_wr_en, map_busy;
   logic [ADDR_W-1:0]    map_rd_addr, map_wr_addr;
   logic [BB-1:0]        map_rd_data, map_wr_data;

   logic [SW-1:0]        list_mem [MAX_FIND];
   logic [SW-1:0]        list_q;
   logic                 list_wr_en, list_rd_en;
   logic [SW-1:0]        list_wr_data;

   logic [CW-1:0]        act_ext, nbytes_c, byte_next_c;
   logic                 in_range, more_bytes;
   logic [WW-1:0]        cnt_ext, want_c;
   logic [BB-1:0]        cur, free_bits, low_oh, bit_oh;
   logic [2:0]           low_bit;
   logic [FW-1:0]        found_inc;
   logic                 accept, emit_last;

   bsa_map_ram #(.DEPTH(MAP_BYTES), .ADDR_W(ADDR_W)) u_map (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (map_rd_en),
      .rd_addr (map_rd_addr),
      .rd_data (map_rd_data),
      .wr_en   (map_wr_en),
      .wr_addr (map_wr_addr),
      .wr_data (map_wr_data),
      .busy    (map_busy)
   );

   // configuration register
   assign csr_bus.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= bsa_pkg::ACTIVE_RESET;
      end else if (csr_bus.valid) begin
         active_ff <= csr_bus.active_bytes;
      end
   end

   // active size clamped to the store depth
   always_comb begin
      act_ext  = CW'(active_ff);
      nbytes_c = (act_ext > CW'(MAP_BYTES)) ? CW'(MAP_BYTES) : act_ext;
      in_range = CW'(req_bus.slot_index >> 3) < nbytes_c;
      cnt_ext  = WW'(req_bus.count);
      if (req_bus.count == '0) begin
         want_c = WW'(1);
      end else if (cnt_ext > WW'(MAX_FIND)) begin
         want_c = WW'(MAX_FIND);
      end else begin
         want_c = cnt_ext;
      end
   end

   // scan datapath: lowest clear bit of the current byte
   always_comb begin
      cur       = fresh_ff ? map_rd_data : work_ff;
      free_bits = ~cur;
      low_bit   = '0;
      for (int b = BB - 1; b >= 0; b--) begin
         if (free_bits[b]) begin
            low_bit = 3'(b);
         end
      end
      low_oh      = BB'(1) << low_bit;
      bit_oh      = BB'(1) << slot_ff[2:0];
      byte_next_c = CW'(byte_ff) + CW'(1);
      more_bytes  = byte_next_c < nbytes_c;
      found_inc   = found_ff + FW'(1);
      emit_last   = (found_ff == emit_ff + FW'(1));
   end

   assign req_bus.ready = (state_ff == bsa_pkg::S_IDLE) && !map_busy;
   assign accept        = req_bus.valid && req_bus.ready;
   assign rsp_free      = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      slot_in       = slot_ff;
      want_in       = want_ff;
      byte_in       = byte_ff;
      found_in      = found_ff;
      emit_in       = emit_ff;
      work_in       = work_ff;
      fresh_in      = fresh_ff;
      res_index_in  = res_index_ff;
      res_bit_in    = res_bit_ff;
      res_status_in = res_status_ff;
      map_rd_en     = 1'b0;
      map_rd_addr   = byte_ff;
      map_wr_en     = 1'b0;
      map_wr_addr   = ADDR_W'(slot_ff >> 3);
      map_wr_data   = map_rd_data;
      list_wr_en    = 1'b0;
      list_wr_data  = SW'({byte_ff, low_bit});
      list_rd_en    = 1'b0;
      rsp_load      = 1'b0;
      rsp_index_in  = res_index_ff;
      rsp_bit_in    = res_bit_ff;
      rsp_status_in = res_status_ff;
      rsp_last_in   = 1'b1;

      case (state_ff)
         bsa_pkg::S_IDLE: begin
            if (accept) begin
               op_in   = req_bus.op;
               slot_in = req_bus.slot_index;
               want_in = FW'(want_c);
               if (req_bus.op == bsa_pkg::OP_FIND) begin
                  found_in = '0;
                  byte_in  = '0;
                  if (nbytes_c == '0) begin
                     res_index_in  = '0;
                     res_bit_in    = 1'b0;
                     res_status_in = bsa_pkg::ST_SHORT;
                     state_in      = bsa_pkg::S_SINGLE;
                  end else begin
                     map_rd_en   = 1'b1;
                     map_rd_addr = '0;
                     fresh_in    = 1'b1;
                     state_in    = bsa_pkg::S_SCAN;
                  end
               end else if (!in_range) begin
                  res_index_in  = req_bus.slot_index;
                  res_bit_in    = 1'b0;
                  res_status_in = bsa_pkg::ST_RANGE;
                  state_in      = bsa_pkg::S_SINGLE;
               end else begin
                  map_rd_en   = 1'b1;
                  map_rd_addr = ADDR_W'(req_bus.slot_index >> 3);
                  state_in    = bsa_pkg::S_MODIFY;
               end
            end
         end

         // read data is back: set/clear modify and write the byte, test reads its bit
         bsa_pkg::S_MODIFY: begin
            res_index_in  = slot_ff;
            res_status_in = bsa_pkg::ST_OK;
            case (op_ff)
               bsa_pkg::OP_SET: begin
                  map_wr_en   = 1'b1;
                  map_wr_data = map_rd_data | bit_oh;
                  res_bit_in  = 1'b1;
               end
               bsa_pkg::OP_CLEAR: begin
                  map_wr_en   = 1'b1;
                  map_wr_data = map_rd_data & ~bit_oh;
                  res_bit_in  = 1'b0;
               end
               default: begin
                  res_bit_in = |(map_rd_data & bit_oh);
               end
            endcase
            state_in = bsa_pkg::S_SINGLE;
         end

         bsa_pkg::S_SINGLE: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               state_in = bsa_pkg::S_IDLE;
            end
         end

         // one free slot or one exhausted byte per cycle
         bsa_pkg::S_SCAN: begin
            if (free_bits != '0) begin
               list_wr_en = 1'b1;
               found_in   = found_inc;
               work_in    = cur | low_oh;
               fresh_in   = 1'b0;
               if (found_inc == want_ff) begin
                  emit_in  = '0;
                  state_in = bsa_pkg::S_EMIT_RD;
               end
            end else if (more_bytes) begin
               byte_in     = ADDR_W'(byte_next_c);
               map_rd_en   = 1'b1;
               map_rd_addr = ADDR_W'(byte_next_c);
               fresh_in    = 1'b1;
            end else if (found_ff == '0) begin
               res_index_in  = '0;
               res_bit_in    = 1'b0;
               res_status_in = bsa_pkg::ST_SHORT;
               state_in      = bsa_pkg::S_SINGLE;
            end else begin
               emit_in  = '0;
               state_in = bsa_pkg::S_EMIT_RD;
            end
         end

         bsa_pkg::S_EMIT_RD: begin
            list_rd_en = 1'b1;
            state_in   = bsa_pkg::S_EMIT_OUT;
         end

         bsa_pkg::S_EMIT_OUT: begin
            rsp_index_in  = list_q;
            rsp_bit_in    = 1'b0;
            rsp_status_in = (found_ff < want_ff) ? bsa_pkg::ST_SHORT : bsa_pkg::ST_OK;
            rsp_last_in   = emit_last;
            if (rsp_free) begin
               rsp_load = 1'b1;
               emit_in  = emit_ff + FW'(1);
               state_in = emit_last ? bsa_pkg::S_IDLE : bsa_pkg::S_EMIT_RD;
            end
         end

         default: begin
            state_in = bsa_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bsa_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      slot_ff       <= slot_in;
      want_ff       <= want_in;
      byte_ff       <= byte_in;
      found_ff      <= found_in;
      emit_ff       <= emit_in;
      work_ff       <= work_in;
      fresh_ff      <= fresh_in;
      res_index_ff  <= res_index_in;
      res_bit_ff    <= res_bit_in;
      res_status_ff <= res_status_in;
   end

   // found-slot list, held until the scan outcome is known
   always_ff @(posedge clock) begin
      if (list_wr_en) begin
         list_mem[LW'(found_ff)] <= list_wr_data;
      end
      if (list_rd_en) begin
         list_q <= list_mem[LW'(emit_ff)];
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_index_ff  <= rsp_index_in;
         rsp_bit_ff    <= rsp_bit_in;
         rsp_status_ff <= rsp_status_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.found_index = rsp_index_ff;
   assign rsp_bus.bit_value   = rsp_bit_ff;
   assign rsp_bus.status      = rsp_status_ff;
   assign rsp_bus.last        = rsp_last_ff;

endmodule

[sv/bsa_checker.sv]
// ---------------------------------------------------------------------------
// bitmap slot allocator port checker
// Watches the top-level ports over time; attached by bind.
// ---------------------------------------------------------------------------
`include "bitmap_slot_allocator_assert.svh"

module bsa_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [bsa_pkg::SLOT_W-1:0]     rsp_found_index,
   input logic                           rsp_bit_value,
   input logic [bsa_pkg::STATUS_W-1:0]   rsp_status,
   input logic                           rsp_last
);

   logic                                   rsp_stall;
   logic                                   range_rsp;
   logic                                   range_ok;
   logic                                   short_rsp;
   logic                                   ports_quiet;
   logic                                   req_seen;
   logic [bsa_pkg::SLOT_W+bsa_pkg::STATUS_W+2:0] rsp_held;

   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign range_rsp   = rsp_valid && (rsp_status == bsa_pkg::ST_RANGE);
   assign range_ok    = rsp_last && !rsp_bit_value;
   assign short_rsp   = rsp_valid && (rsp_status == bsa_pkg::ST_SHORT);
   assign ports_quiet = !req_ready && !rsp_valid;
   assign req_seen    = req_valid && req_ready;
   assign rsp_held    = {rsp_valid, rsp_found_index, rsp_bit_value, rsp_status, rsp_last};

   // a stalled response stays valid and keeps its payload
   `BSA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, $stable(rsp_held), "stall not held")

   // out of range ends the transaction with a cleared bit
   `BSA_ASSERT_IMPL(a_range_single, clock, reset, range_rsp, range_ok, "range response malformed")

   // a short find reports free slots only
   `BSA_ASSERT_IMPL(a_short_free, clock, reset, short_rsp, !rsp_bit_value, "short find bit set")

   // bitmap sweep after reset holds off requests and responses
   `BSA_ASSERT_IMPL(a_reset_quiet, clock, reset, $past(reset), ports_quiet, "active after reset")

   `BSA_ASSERT_IMPL(a_sweep_no_accept, clock, reset, $past(reset), !req_seen, "early accept")

endmodule

bind bitmap_slot_allocator bsa_checker u_bsa_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_found_index (rsp_bus.found_index),
   .rsp_bit_value   (rsp_bus.bit_value),
   .rsp_status      (rsp_bus.status),
   .rsp_last        (rsp_bus.last)
);
